[rtl/core/pipeline_prime_sieve_top_defines.svh]
// Assertion macros for the prime sieve block.
`ifndef PIPELINE_PRIME_SIEVE_TOP_DEFINES_SVH
`define PIPELINE_PRIME_SIEVE_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked on the same edge.
`define PPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the next edge.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pps_pkg.sv]
// Shared constants for the prime sieve block.
package pps_pkg;

    localparam int unsigned NUM_CELLS     = 64;
    localparam int unsigned VALUE_BITS    = 16;
    localparam int unsigned CAND_BITS     = 16;
    localparam int unsigned MIN_CANDIDATE = 2;

    localparam int unsigned IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_CELLS + 1);
    localparam int unsigned BIT_W = $clog2(VALUE_BITS);

endpackage

[rtl/core/pps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/pipeline_prime_sieve_top.sv]
// Prime sieve: stored-prime chain in RAM, tested by one shared bit-serial remainder unit.
//
//  channel   dir  tdata                        tuser
//  s_axis    in   [15:0] candidate             [0] restart
//  m_axis    out  [15:0] prime_value           [0] undetermined
//
// A candidate below two gives no result. A restart or an empty chain goes straight to emit;
// otherwise each stored prime is tested (RAM read, load, one quotient bit per cycle, check)
// by the shared restoring remainder unit; a divisible request stops at the first dividing
// prime, a prime tests them all and then goes to the emit state.
// Reset (i_rst_n low, synchronous) empties the chain; the RAM needs no clearing.
// s_axis_tready is high only while idle; the emit cycle waits while a shown result is held.
module pipeline_prime_sieve_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pps_pkg::CAND_BITS-1:0]  s_axis_tdata,  // [15:0] candidate
    input  logic                           s_axis_tuser,  // [0] restart
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pps_pkg::CAND_BITS-1:0]  m_axis_tdata,  // [15:0] prime_value
    output logic                           m_axis_tuser   // [0] undetermined
);

    `include "pipeline_prime_sieve_top_defines.svh"

    localparam int unsigned VB = pps_pkg::VALUE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic [VB-1:0]             r_cand;
    logic [VB-1:0]             r_dvd;
    logic [VB-1:0]             r_div;
    logic [VB-1:0]             r_rem;
    logic [pps_pkg::BIT_W-1:0] r_bit;
    logic [pps_pkg::IDX_W-1:0] r_idx;
    logic [pps_pkg::CNT_W-1:0] r_used;
    logic                      r_out_valid;
    logic [pps_pkg::CAND_BITS-1:0] r_out_data;
    logic                      r_out_user;

    logic                      w_accept;
    logic [VB-1:0]             w_in_cand;
    logic                      w_out_free;
    logic                      w_emit;
    logic                      w_testing;
    logic                      w_full;
    logic                      w_ram_we;
    logic [VB-1:0]             w_ram_rdata;
    logic [VB:0]               w_trial;
    logic [VB:0]               w_sub;
    logic [VB-1:0]             n_rem;
    logic                      w_divisible;
    logic                      w_last_cell;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_cand     = VB'(s_axis_tdata);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_emit        = (r_state == S_EMIT) && w_out_free;
    assign w_testing     = (r_state == S_READ) || (r_state == S_CHECK);
    assign w_full        = (r_used == pps_pkg::CNT_W'(pps_pkg::NUM_CELLS));
    assign w_ram_we      = w_emit && !w_full;

    // restoring remainder step: shift in the next dividend bit, subtract if it fits
    assign w_trial     = {r_rem, r_dvd[VB-1]};
    assign w_sub       = w_trial - {1'b0, r_div};
    assign n_rem       = w_sub[VB] ? w_trial[VB-1:0] : w_sub[VB-1:0];
    assign w_divisible = (r_div != '0) && (r_rem == '0);
    assign w_last_cell = ((pps_pkg::CNT_W'(r_idx) + pps_pkg::CNT_W'(1)) == r_used);

    pps_ram #(
        .WIDTH (VB),
        .DEPTH (pps_pkg::NUM_CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_used[pps_pkg::IDX_W-1:0]),
        .i_wdata (r_cand),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cand <= w_in_cand;
                        r_idx  <= '0;
                        if (s_axis_tuser) begin
                            r_used <= '0;
                        end
                        if (w_in_cand < VB'(pps_pkg::MIN_CANDIDATE)) begin
                            r_state <= S_IDLE;
                        end else if (s_axis_tuser || r_used == '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_div   <= w_ram_rdata;
                    r_dvd   <= r_cand;
                    r_rem   <= '0;
                    r_bit   <= pps_pkg::BIT_W'(VB - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[VB-2:0], 1'b0};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_divisible) begin
                        r_state <= S_IDLE;
                    end else if (w_last_cell) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_data  <= pps_pkg::CAND_BITS'(r_cand);
                        r_out_user  <= w_full;
                        if (!w_full) begin
                            r_used <= r_used + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `PPS_ASSERT(a_used_bound, r_used <= pps_pkg::CNT_W'(pps_pkg::NUM_CELLS), "cell count overflow")
    `PPS_ASSERT_IMPL(a_we_not_full, w_ram_we, !w_full, "cell written with chain full")
    `PPS_ASSERT_IMPL(a_idx_in_use, w_testing, pps_pkg::CNT_W'(r_idx) < r_used, "unfilled cell read")
    `PPS_ASSERT_NEXT(a_emit_shows, w_emit, r_out_valid && r_state == S_IDLE, "no result shown")

endmodule
